// ===== rtl/core/checksummed_frame_speed_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// checksummed_frame_speed_decoder_assert.svh
// Assertion macros used by the frame speed decoder top level.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_SPEED_DECODER_ASSERT_SVH
`define CHECKSUMMED_FRAME_SPEED_DECODER_ASSERT_SVH

// a implies b in the same cycle
`define CFSD_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");

// expression must never hold
`define CFSD_ASSERT_NEVER(label, clk, rst, a) \
   label: assert property (@(posedge clk) disable iff (rst) !(a)) \
      else $error("forbidden condition seen");

`endif

// ===== rtl/core/cfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfsd_pkg
// Types and constants of the checksummed frame speed decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfsd_pkg;

   localparam logic [7:0] START_BYTE = 8'd2;
   localparam int PERIOD_HI_POS = 8;
   localparam int PERIOD_LO_POS = 9;

   localparam int WHEEL_W  = 6;
   localparam int PERIOD_W = 16;
   localparam int SPEED_W  = 16;

   // 2871216 * 256 / 10000 reduced: 45939456 / 625
   localparam int NUM_W = 32;
   localparam int DEN_W = 26;
   localparam int QUO_W = 18;
   localparam int DIV_W = DEN_W + QUO_W - 1;
   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [NUM_W-1:0] SPEED_NUM_K = 32'd45939456;
   localparam logic [DEN_W-1:0] SPEED_DEN_K = 26'd625;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

   localparam int JOB_DEPTH = 2;

   typedef struct packed {
      logic                checksum_ok;
      logic [PERIOD_W-1:0] period;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/checksummed_frame_speed_decoder.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_speed_decoder
// Checksummed serial frame receiver with wheel speed decoder.
//
// Input bytes are pushed one word at a time (req_push / req_full). A frame
// starts with byte 2, then a length byte equal to FRAME_LENGTH; bytes 8 and 9
// carry the big-endian wheel period and the last byte is the XOR checksum.
// On the checksum byte the frame goes into a two-entry job queue; the speed
// unit pops it and drives one result word (rsp_empty / rsp_pop).
// Every byte is taken in one cycle while the job queue has room.
// From the checksum byte a frame passes through the job queue and the speed
// unit's idle and load states; a stopped or zero period then goes straight
// to the result, else the 18-step restoring divider runs first. The speed
// unit takes the next frame from the queue only once its result is popped.
// A result stays on the rsp ports until popped; while it waits the parser
// keeps taking bytes until two more frames are queued, then req_full rises.
// Registers: 0x0 wheel_size_inch (reset 20), 0x4 stop_period (reset 3000).
// Reset returns the parser to hunting, empties the queue and drops any
// pending result; it takes effect on the next clock edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module checksummed_frame_speed_decoder #(
   parameter int FRAME_LENGTH = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_checksum_ok,
   output logic [15:0]      rsp_wheel_period,
   output logic [15:0]      rsp_speed_q8,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

`include "checksummed_frame_speed_decoder_assert.svh"

   localparam int WHEEL_W  = cfsd_pkg::WHEEL_W;
   localparam int PERIOD_W = cfsd_pkg::PERIOD_W;
   localparam logic [WHEEL_W-1:0]  WHEEL_RESET = 6'd20;
   localparam logic [PERIOD_W-1:0] STOP_RESET  = 16'd3000;
   localparam logic REG_WHEEL = 1'b0;
   localparam logic REG_STOP  = 1'b1;

   logic [WHEEL_W-1:0]  wheel_ff, wheel_in;
   logic [PERIOD_W-1:0] stop_ff, stop_in;
   logic                csr_write;

   logic                       word_accept;
   logic                       job_push;
   cfsd_pkg::job_type          job_wr;
   cfsd_pkg::job_type          job_rd;
   logic                       job_pop;
   cfsd_pkg::queue_status_type q_status;
   logic                       out_valid;
   logic                       rsp_over_stop;
   logic                       rsp_zero_period;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      wheel_in = wheel_ff;
      stop_in  = stop_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_WHEEL: wheel_in = csr_pwdata[WHEEL_W-1:0];
            REG_STOP:  stop_in  = csr_pwdata[PERIOD_W-1:0];
            default:   wheel_in = wheel_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_WHEEL: csr_prdata = {(32 - WHEEL_W)'(0), wheel_ff};
         REG_STOP:  csr_prdata = {(32 - PERIOD_W)'(0), stop_ff};
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_ff <= WHEEL_RESET;
         stop_ff  <= STOP_RESET;
      end else begin
         wheel_ff <= wheel_in;
         stop_ff  <= stop_in;
      end
   end

   assign req_full    = q_status.full;
   assign word_accept = req_push && !req_full;

   cfsd_front #(
      .FRAME_LENGTH(FRAME_LENGTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .word_accept (word_accept),
      .rx_byte     (req_rx_byte),
      .job_push    (job_push),
      .job         (job_wr)
   );

   cfsd_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr),
      .pop       (job_pop),
      .pop_data  (job_rd),
      .status    (q_status)
   );

   cfsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_data          (job_rd),
      .q_pop           (job_pop),
      .wheel_size_inch (wheel_ff),
      .stop_period     (stop_ff),
      .out_valid       (out_valid),
      .out_pop         (rsp_pop),
      .checksum_ok     (rsp_checksum_ok),
      .wheel_period    (rsp_wheel_period),
      .speed_q8        (rsp_speed_q8)
   );

   assign rsp_empty = !out_valid;

   assign rsp_over_stop   = !rsp_empty && (rsp_wheel_period > stop_ff);
   assign rsp_zero_period = !rsp_empty && (rsp_wheel_period == '0);

   `CFSD_ASSERT_NEVER(a_push_when_full, clock, reset, job_push && q_status.full)
   `CFSD_ASSERT_IMPL(a_stop_zero, clock, reset, rsp_over_stop, rsp_speed_q8 == '0)
   `CFSD_ASSERT_IMPL(a_zero_sat, clock, reset, rsp_zero_period, rsp_speed_q8 == '1)

endmodule

`default_nettype wire

// ===== rtl/core/cfsd_front.sv =====
// ----------------------------------------------------------------------------
// cfsd_front
// Frame parser: start/length hunt, running XOR, period capture.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfsd_front #(
   parameter int FRAME_LENGTH = 14
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             word_accept,
   input  wire logic [7:0]       rx_byte,
   output logic                  job_push,
   output cfsd_pkg::job_type     job
);

   localparam int POS_W = $clog2(FRAME_LENGTH);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LENGTH - 1);
   localparam logic [POS_W-1:0] POS_HI = POS_W'(cfsd_pkg::PERIOD_HI_POS);
   localparam logic [POS_W-1:0] POS_LO = POS_W'(cfsd_pkg::PERIOD_LO_POS);
   localparam logic [7:0] LEN_BYTE = 8'(FRAME_LENGTH);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       phi_ff, phi_in;
   logic [7:0]       plo_ff, plo_in;

   always_comb begin
      pos_in   = pos_ff;
      xor_in   = xor_ff;
      phi_in   = phi_ff;
      plo_in   = plo_ff;
      job_push = 1'b0;
      if (word_accept) begin
         if (pos_ff == '0) begin
            if (rx_byte == cfsd_pkg::START_BYTE) begin
               xor_in = rx_byte;
               pos_in = POS_W'(1);
            end
         end else if (pos_ff == POS_W'(1)) begin
            if (rx_byte != LEN_BYTE) begin
               pos_in = '0;
            end else begin
               xor_in = xor_ff ^ rx_byte;
               pos_in = POS_W'(2);
            end
         end else if (pos_ff == POS_LAST) begin
            pos_in   = '0;
            job_push = 1'b1;
         end else begin
            if (pos_ff == POS_HI) begin
               phi_in = rx_byte;
            end
            if (pos_ff == POS_LO) begin
               plo_in = rx_byte;
            end
            xor_in = xor_ff ^ rx_byte;
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   assign job.checksum_ok = (xor_ff == rx_byte);
   assign job.period      = {phi_ff, plo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         xor_ff <= '0;
         phi_ff <= '0;
         plo_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         xor_ff <= xor_in;
         phi_ff <= phi_in;
         plo_ff <= plo_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cfsd_job_queue.sv =====
// ----------------------------------------------------------------------------
// cfsd_job_queue
// Short FIFO of finished frames between parser and speed unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfsd_job_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire cfsd_pkg::job_type     push_data,
   input  wire logic                  pop,
   output cfsd_pkg::job_type          pop_data,
   output cfsd_pkg::queue_status_type status
);

   localparam int DEPTH = cfsd_pkg::JOB_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cfsd_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cfsd_back.sv =====
// ----------------------------------------------------------------------------
// cfsd_back
// Speed unit: range checks, restoring divider, result holding register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfsd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cfsd_pkg::queue_status_type    q_status,
   input  wire cfsd_pkg::job_type             q_data,
   output logic                               q_pop,
   input  wire logic [cfsd_pkg::WHEEL_W-1:0]  wheel_size_inch,
   input  wire logic [cfsd_pkg::PERIOD_W-1:0] stop_period,
   output logic                               out_valid,
   input  wire logic                          out_pop,
   output logic                               checksum_ok,
   output logic [cfsd_pkg::PERIOD_W-1:0]      wheel_period,
   output logic [cfsd_pkg::SPEED_W-1:0]       speed_q8
);

   localparam int NUM_W = cfsd_pkg::NUM_W;
   localparam int DEN_W = cfsd_pkg::DEN_W;
   localparam int QUO_W = cfsd_pkg::QUO_W;
   localparam int DIV_W = cfsd_pkg::DIV_W;
   localparam int CNT_W = cfsd_pkg::CNT_W;
   localparam int SPEED_W = cfsd_pkg::SPEED_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   cfsd_pkg::job_type  job_ff, job_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;

   logic [NUM_W-1:0] num_w;
   logic [DEN_W-1:0] den_w;
   logic             fits;

   assign num_w = cfsd_pkg::SPEED_NUM_K * NUM_W'(wheel_size_inch);
   assign den_w = cfsd_pkg::SPEED_DEN_K * DEN_W'(job_ff.period);
   assign fits  = (DIV_W'(rem_ff) >= div_ff);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      speed_in = speed_ff;
      q_pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               job_in   = q_data;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (job_ff.period > stop_period) begin
               speed_in = '0;
               state_in = ST_HOLD;
            end else if (job_ff.period == '0) begin
               speed_in = cfsd_pkg::SPEED_MAX;
               state_in = ST_HOLD;
            end else begin
               rem_in   = num_w;
               div_in   = {den_w, (QUO_W - 1)'(0)};
               quo_in   = '0;
               cnt_in   = CNT_W'(QUO_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (fits) begin
               rem_in = rem_ff - div_ff[NUM_W-1:0];
            end
            quo_in = {quo_ff[QUO_W-2:0], fits};
            div_in = div_ff >> 1;
            if (cnt_ff == '0) begin
               speed_in = (quo_in[QUO_W-1:SPEED_W] != '0) ? cfsd_pkg::SPEED_MAX
                                                           : quo_in[SPEED_W-1:0];
               state_in = ST_HOLD;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_HOLD: begin
            if (out_pop) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid    = (state_ff == ST_HOLD);
   assign checksum_ok  = job_ff.checksum_ok;
   assign wheel_period = job_ff.period;
   assign speed_q8     = speed_ff;

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      speed_ff <= speed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
